// ===== rtl/lfu_block_cache_unit_assert.svh =====
// Assertion macros for the block cache unit
`ifndef LFU_BLOCK_CACHE_UNIT_ASSERT_SVH
`define LFU_BLOCK_CACHE_UNIT_ASSERT_SVH
`define LBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LFU block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;
   localparam int NumEntries = 64;
   localparam int BlockWords = 32;
   localparam int SlotW = $clog2(NumEntries);
   localparam int WordW = $clog2(BlockWords);
   localparam int AddrW = SlotW + WordW;
   localparam logic [15:0] UseMax = 16'hFFFF;

   localparam logic [1:0] OpLookup = 2'd0;
   localparam logic [1:0] OpInsert = 2'd1;
   localparam logic [1:0] OpUpdate = 2'd2;
   localparam logic [1:0] OpNone   = 2'd3;

   localparam logic [1:0] StDone     = 2'd0;
   localparam logic [1:0] StMiss     = 2'd1;
   localparam logic [1:0] StDisabled = 2'd2;
   localparam logic [1:0] StDup      = 2'd3;

   // Token passed along the cell chain during a search.
   typedef struct packed {
      logic             found;
      logic [SlotW-1:0] found_slot;
      logic             free;
      logic [SlotW-1:0] free_slot;
      logic [15:0]      best_cnt;
      logic [SlotW-1:0] best_slot;
   } scan_type;

   // Per-cell control broadcast from the sequencer.
   typedef struct packed {
      logic       clear_all;
      logic       claim;
      logic       set_one;
      logic       bump;
      logic [3:0] disk;
      logic [7:0] blk;
   } cell_ctl_type;
endpackage

// ===== rtl/lbc_cell.sv =====
// ----------------------------------------------------------------------------
// lbc_cell
// One cache entry: valid bit, tag and use count; folds itself into the
// search token and hands it to the next cell.
// ----------------------------------------------------------------------------
module lbc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [lbc_pkg::SlotW-1:0] my_slot,
   input  logic                    active,
   input  lbc_pkg::cell_ctl_type   ctl,
   input  logic                    sel,
   input  lbc_pkg::scan_type       scan_in,
   output lbc_pkg::scan_type       scan_out
);
   import lbc_pkg::*;

   logic        valid_ff, valid_in;
   logic [3:0]  disk_ff, disk_in;
   logic [7:0]  blk_ff, blk_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        hit;

   assign hit = active && valid_ff && disk_ff == ctl.disk && blk_ff == ctl.blk;

   always_comb begin
      scan_out = scan_in;
      if (active) begin
         if (hit && !scan_in.found) begin
            scan_out.found = 1'b1;
            scan_out.found_slot = my_slot;
         end
         if (!valid_ff && !scan_in.free) begin
            scan_out.free = 1'b1;
            scan_out.free_slot = my_slot;
         end
         if (valid_ff && (my_slot == '0 || scan_in.best_cnt > cnt_ff)) begin
            scan_out.best_cnt = cnt_ff;
            scan_out.best_slot = my_slot;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      disk_in = disk_ff;
      blk_in = blk_ff;
      cnt_in = cnt_ff;
      if (ctl.clear_all) begin
         valid_in = 1'b0;
      end else if (sel) begin
         if (ctl.claim) begin
            valid_in = 1'b1;
            disk_in = ctl.disk;
            blk_in = ctl.blk;
         end
         if (ctl.set_one) begin
            cnt_in = 16'd1;
         end else if (ctl.bump && cnt_ff != UseMax) begin
            cnt_in = cnt_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      disk_ff <= disk_in;
      blk_ff <= blk_in;
      cnt_ff <= cnt_in;
   end
endmodule

// ===== rtl/lbc_chain.sv =====
// ----------------------------------------------------------------------------
// lbc_chain
// Row of entry cells with a registered search token every eight cells.
// ----------------------------------------------------------------------------
module lbc_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [6:0]                active_n,
   input  lbc_pkg::cell_ctl_type     ctl,
   input  logic                      sel_valid,
   input  logic [lbc_pkg::SlotW-1:0] sel_slot,
   output lbc_pkg::scan_type         result
);
   import lbc_pkg::*;

   localparam int Seg = 8;
   localparam int NumSeg = (NumEntries + Seg - 1) / Seg;

   scan_type link [NumEntries+1];
   scan_type seg_ff [NumSeg];
   scan_type seg_in [NumSeg];

   assign link[0] = '0;

   for (genvar i = 0; i < NumEntries; i++) begin : g_cell
      scan_type cin;
      if (i % Seg == 0 && i != 0) begin : g_reg
         assign cin = seg_ff[i/Seg - 1];
      end else begin : g_wire
         assign cin = link[i];
      end
      lbc_cell u_cell (
         .clock(clock), .reset(reset), .my_slot(SlotW'(i)),
         .active(7'(i) < active_n), .ctl(ctl),
         .sel(sel_valid && sel_slot == SlotW'(i)),
         .scan_in(cin), .scan_out(link[i+1]));
      if (i % Seg == Seg - 1 || i == NumEntries - 1) begin : g_tap
         assign seg_in[i/Seg] = link[i+1];
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign result = seg_ff[NumSeg-1];
endmodule

// ===== rtl/lfu_block_cache_unit.sv =====
// A follow-on write beat goes through the write state to the response beat;
// word 0 of insert/update and a lookup go through tag search, decide and the
// response beat, skipping the search while the cache is disabled. A lookup hit
// then sends its 32 words, each after its registered block store read.
// Throughput: one item at a time; a stalled response beat holds the sequencer.
// Reset: synchronous; clears valid bits, counters and pending state.
// ----------------------------------------------------------------------------
// lfu_block_cache_unit
// Fully associative LFU block cache with streamed block read-out.
// ----------------------------------------------------------------------------
module lfu_block_cache_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_disk_id,
   input  logic [7:0]  req_block_id,
   input  logic [4:0]  req_word_index,
   input  logic [63:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_read_word,
   output logic [4:0]  rsp_read_index,
   output logic        rsp_last,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_query_total
);
   import lbc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DECIDE = 6'b000100,
      S_WRITE = 6'b001000, S_READ = 6'b010000, S_EMIT = 6'b100000
   } state_type;

   localparam int ScanCycles = NumEntries / 8 + 1;

   state_type st_ff, st_in;
   logic [6:0] eiu_ff;
   logic [6:0] act_n;
   logic [1:0] op_ff;
   logic [3:0] disk_ff;
   logic [7:0] blk_ff;
   logic [4:0] widx_ff;
   logic [63:0] data_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic [SlotW-1:0] pslot_ff, pslot_in;
   logic [SlotW-1:0] rslot_ff, rslot_in;
   logic [1:0] pstat_ff, pstat_in;
   logic [31:0] hits_ff, hits_in, qry_ff, qry_in;
   logic [WordW:0] rd_ff, rd_in;
   logic [63:0] mem [NumEntries*BlockWords];
   logic [63:0] mem_q;
   logic mem_we;
   logic [AddrW-1:0] rd_addr;
   cell_ctl_type ctl;
   logic sel_valid;
   logic [SlotW-1:0] sel_slot;
   scan_type res;
   logic rsp_v_ff, rsp_v_in, rsp_l_ff, rsp_l_in, rd_pend_ff, rd_pend_in;
   logic [1:0] rsp_s_ff, rsp_s_in;
   logic [63:0] rsp_w_ff;
   logic [4:0] rsp_i_ff, rsp_i_in;
   logic out_free, acc, disabled, rsp_load;

   assign act_n = (eiu_ff > 7'(NumEntries)) ? 7'(NumEntries) : eiu_ff;
   assign disabled = act_n < 7'd2;
   assign out_free = !rsp_v_ff || (!rd_pend_ff && !rsp_stall);
   assign rsp_load = rsp_v_in && out_free;
   assign req_stall = st_ff != S_IDLE;
   assign acc = req_valid && !req_stall;

   lbc_chain u_chain (
      .clock(clock), .reset(reset), .active_n(act_n), .ctl(ctl),
      .sel_valid(sel_valid), .sel_slot(sel_slot), .result(res));

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; pslot_in = pslot_ff; pstat_in = pstat_ff;
      rslot_in = rslot_ff;
      hits_in = hits_ff; qry_in = qry_ff; rd_in = rd_ff;
      rsp_v_in = !out_free; rsp_s_in = rsp_s_ff; rsp_i_in = rsp_i_ff;
      rsp_l_in = rsp_l_ff; rd_pend_in = 1'b0; mem_we = 1'b0;
      ctl = '0; ctl.disk = disk_ff; ctl.blk = blk_ff; ctl.clear_all = csr_we;
      sel_valid = 1'b0; sel_slot = res.found_slot;
      rd_addr = {rslot_ff, rd_ff[WordW-1:0]};
      unique case (st_ff)
         S_IDLE: begin
            if (acc) begin
               cnt_in = '0;
               if (req_op == OpNone) st_in = S_IDLE;
               else if (req_op == OpLookup || req_word_index == 5'd0) begin
                  st_in = disabled ? S_DECIDE : S_SCAN;
               end else st_in = S_WRITE;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(ScanCycles - 1)) st_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (op_ff == OpLookup) begin
               if (out_free) begin
                  if (disabled) begin
                     rsp_s_in = StDisabled; st_in = S_EMIT;
                  end else begin
                     qry_in = qry_ff + 32'd1;
                     if (!res.found) begin
                        rsp_s_in = StMiss; st_in = S_EMIT;
                     end else begin
                        hits_in = hits_ff + 32'd1;
                        ctl.bump = 1'b1; sel_valid = 1'b1;
                        rslot_in = res.found_slot; rd_in = '0; st_in = S_READ;
                     end
                  end
                  rsp_i_in = '0; rsp_l_in = 1'b1;
               end
            end else begin
               if (disabled) pstat_in = StDisabled;
               else if (op_ff == OpInsert) begin
                  if (res.found) pstat_in = StDup;
                  else begin
                     pstat_in = StDone; ctl.claim = 1'b1; ctl.set_one = 1'b1;
                     sel_valid = 1'b1;
                     sel_slot = res.free ? res.free_slot : res.best_slot;
                     pslot_in = sel_slot;
                  end
               end else begin
                  if (!res.found) pstat_in = StMiss;
                  else begin
                     pstat_in = StDone; ctl.set_one = 1'b1; sel_valid = 1'b1;
                     pslot_in = res.found_slot;
                  end
               end
               st_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               mem_we = pstat_ff == StDone && 32'(widx_ff) < 32'(BlockWords);
               rsp_v_in = 1'b1; rsp_s_in = pstat_ff; rsp_i_in = widx_ff;
               rsp_l_in = 32'(widx_ff) == 32'(BlockWords - 1);
               st_in = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               rd_pend_in = 1'b1; rsp_v_in = 1'b1; rsp_s_in = StDone;
               rsp_i_in = 5'(rd_ff);
               rsp_l_in = rd_ff == (WordW+1)'(BlockWords - 1);
               rd_in = rd_ff + 1'b1;
               if (rd_ff == (WordW+1)'(BlockWords - 1)) st_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_v_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[{pslot_ff, widx_ff[WordW-1:0]}] <= data_ff;
      mem_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; eiu_ff <= '0; cnt_ff <= '0; pslot_ff <= '0;
         rslot_ff <= '0;
         pstat_ff <= '0; hits_ff <= '0; qry_ff <= '0; rd_ff <= '0;
         rsp_v_ff <= 1'b0; rd_pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; pslot_ff <= pslot_in;
         rslot_ff <= rslot_in;
         pstat_ff <= pstat_in; hits_ff <= hits_in; qry_ff <= qry_in;
         rd_ff <= rd_in; rsp_v_ff <= rsp_v_in; rd_pend_ff <= rd_pend_in;
         if (csr_we) eiu_ff <= csr_wdata;
      end
      if (acc) begin
         op_ff <= req_op; disk_ff <= req_disk_id; blk_ff <= req_block_id;
         widx_ff <= req_word_index; data_ff <= req_data_word;
      end
      rsp_s_ff <= rsp_s_in; rsp_i_ff <= rsp_i_in; rsp_l_ff <= rsp_l_in;
   end

   // hold read data while stalled; the read data passes through mem_q into rw_ff
   logic [63:0] rw_ff, rw_in;
   always_comb begin
      rw_in = rw_ff;
      if (rsp_load) rw_in = '0;
      if (rd_pend_ff) rw_in = mem_q;
   end
   always_ff @(posedge clock) begin
      rw_ff <= rw_in;
   end
   assign rsp_w_ff = rw_ff;

   logic [31:0] ht_ff, qt_ff;
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         ht_ff <= hits_in; qt_ff <= qry_in;
      end
   end

   assign rsp_valid = rsp_v_ff && !rd_pend_ff;
   assign rsp_status = rsp_s_ff;
   assign rsp_read_word = rsp_w_ff;
   assign rsp_read_index = rsp_i_ff;
   assign rsp_last = rsp_l_ff;
   assign rsp_hit_total = ht_ff;
   assign rsp_query_total = qt_ff;
endmodule

// ===== rtl/lbc_checker.sv =====
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks of the block cache unit.
// ----------------------------------------------------------------------------
`include "lfu_block_cache_unit_assert.svh"
module lbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_read_word,
   input logic [31:0] rsp_hit_total,
   input logic [31:0] rsp_query_total
);
   import lbc_pkg::*;

   `LBC_ASSERT_IMPL(a_hits_le, clock, reset, rsp_valid,
      rsp_hit_total <= rsp_query_total || rsp_query_total < 32'd4, "hits exceed queries")
   `LBC_ASSERT_IMPL(a_zero_word, clock, reset, rsp_valid && rsp_status != StDone,
      rsp_read_word == 64'd0, "nonzero word on non-hit")
   `LBC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status), "beat dropped under stall")
endmodule

bind lfu_block_cache_unit lbc_checker u_lbc_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_read_word(rsp_read_word), .rsp_hit_total(rsp_hit_total),
   .rsp_query_total(rsp_query_total));

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LFU block cache unit. A cycle-free predictor
// tracks tags, use counts, block data and counters. Every accepted request
// beat but OpNone pushes its expected response beats; the monitor compares
// each one field by field. Directed tests cover the disabled cache, a block
// fill with lookups, a duplicate insert and an update miss. Random phases
// send whole blocks, lookups and stray beats at several cache sizes.
// ----------------------------------------------------------------------------
module tb_top;
   import lbc_pkg::*;

   localparam int StoreDepth = NumEntries * BlockWords;
   localparam int OpWaitCycles = 40;
   localparam int WatchLimit = 20000;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] word;
      logic [4:0]  index;
      logic        last;
      logic [31:0] hits;
      logic [31:0] queries;
   } rsp_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OpNone;
   logic [3:0]  req_disk_id = '0;
   logic [7:0]  req_block_id = '0;
   logic [4:0]  req_word_index = '0;
   logic [63:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_read_word;
   logic [4:0]  rsp_read_index;
   logic        rsp_last;
   logic [31:0] rsp_hit_total;
   logic [31:0] rsp_query_total;

   lfu_block_cache_unit dut (.*);

   // cache image kept by the predictor
   int          active_n;
   bit          ent_valid [NumEntries];
   logic [3:0]  ent_disk  [NumEntries];
   logic [7:0]  ent_blk   [NumEntries];
   int          ent_uses  [NumEntries];
   logic [63:0] blk_data  [StoreDepth];
   bit          blk_written [StoreDepth];
   logic [31:0] hit_cnt, query_cnt;
   int          cur_slot;
   logic [1:0]  cur_status;

   rsp_beat_t   pending_rsp_q [$];
   int          failures = 0;
   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          quiet_cycles = 0;
   logic [3:0]  pool_disk [6];
   logic [7:0]  pool_blk  [6];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int find_entry(logic [3:0] disk, logic [7:0] blk);
      for (int i = 0; i < active_n; i++)
         if (ent_valid[i] && ent_disk[i] == disk && ent_blk[i] == blk) return i;
      return -1;
   endfunction

   function automatic int pick_victim();
      int best;
      best = 0;
      for (int i = 0; i < active_n; i++) begin
         if (!ent_valid[i]) return i;
         if (ent_uses[best] > ent_uses[i]) best = i;
      end
      return best;
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic [63:0] w, logic [4:0] idx,
                                    logic lst);
      rsp_beat_t b;
      b.status = st;
      b.word = w;
      b.index = idx;
      b.last = lst;
      b.hits = hit_cnt;
      b.queries = query_cnt;
      pending_rsp_q.push_back(b);
   endfunction

   function automatic void cache_predict(logic [1:0] op, logic [3:0] disk, logic [7:0] blk,
                                         logic [4:0] widx, logic [63:0] data);
      int s;
      if (op == OpNone) return;
      if (op == OpLookup) begin
         if (active_n < 2) begin
            push_rsp(StDisabled, '0, '0, 1'b1);
            return;
         end
         query_cnt++;
         s = find_entry(disk, blk);
         if (s < 0) begin
            push_rsp(StMiss, '0, '0, 1'b1);
            return;
         end
         hit_cnt++;
         if (ent_uses[s] < int'(UseMax)) ent_uses[s]++;
         for (int k = 0; k < BlockWords; k++)
            push_rsp(StDone, blk_data[s*BlockWords+k], k[4:0], k == BlockWords-1);
         return;
      end
      if (widx == 0) begin
         if (active_n < 2) begin
            cur_status = StDisabled;
         end else if (op == OpInsert) begin
            if (find_entry(disk, blk) >= 0) begin
               cur_status = StDup;
            end else begin
               s = pick_victim();
               ent_valid[s] = 1'b1;
               ent_disk[s] = disk;
               ent_blk[s] = blk;
               ent_uses[s] = 1;
               cur_slot = s;
               cur_status = StDone;
            end
         end else begin
            s = find_entry(disk, blk);
            if (s < 0) begin
               cur_status = StMiss;
            end else begin
               ent_uses[s] = 1;
               cur_slot = s;
               cur_status = StDone;
            end
         end
      end
      if (cur_status == StDone) begin
         blk_data[cur_slot*BlockWords+widx] = data;
         blk_written[cur_slot*BlockWords+widx] = 1'b1;
      end
      push_rsp(cur_status, '0, widx, widx == BlockWords-1);
   endfunction

   // true when a lookup would read a block word that was never written
   function automatic bit reads_unwritten(logic [3:0] disk, logic [7:0] blk);
      int s;
      if (active_n < 2) return 1'b0;
      s = find_entry(disk, blk);
      if (s < 0) return 1'b0;
      for (int k = 0; k < BlockWords; k++)
         if (!blk_written[s*BlockWords+k]) return 1'b1;
      return 1'b0;
   endfunction

   task automatic send_beat(logic [1:0] op, logic [3:0] disk, logic [7:0] blk,
                            logic [4:0] widx, logic [63:0] data);
      if (op == OpLookup && reads_unwritten(disk, blk)) return;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_disk_id <= disk;
      req_block_id <= blk;
      req_word_index <= widx;
      req_data_word <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cache_predict(op, disk, blk, widx, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (OpWaitCycles) @(posedge clock);
   endtask

   task automatic write_entries(logic [6:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      active_n = (value > NumEntries) ? NumEntries : value;
      for (int i = 0; i < NumEntries; i++) ent_valid[i] = 1'b0;
   endtask

   task automatic send_block(logic [1:0] op, logic [3:0] disk, logic [7:0] blk,
                             int lookup_pct, ref int sent);
      for (int w = 0; w < BlockWords; w++) begin
         send_beat(op, disk, blk, w[4:0], {$urandom, $urandom});
         sent++;
         if ($urandom_range(99) < lookup_pct) begin
            send_beat(OpLookup, pool_disk[$urandom_range(5)], pool_blk[$urandom_range(5)],
                      5'($urandom), {$urandom, $urandom});
            sent++;
         end
      end
   endtask

   task automatic test_disabled();
      send_beat(OpLookup, 4'd15, 8'd255, 5'd31, '1);
      send_beat(OpInsert, 4'd0, 8'd0, 5'd0, '0);
      send_beat(OpInsert, 4'd0, 8'd0, 5'd31, '1);
      send_beat(OpUpdate, 4'd15, 8'd255, 5'd0, '1);
      send_beat(OpNone, 4'd15, 8'd255, 5'd31, '1);
      write_entries(7'd1);
      send_beat(OpLookup, 4'd0, 8'd0, 5'd0, '0);
   endtask

   task automatic test_fill_and_lookup();
      write_entries(7'd127);
      for (int w = 0; w < BlockWords; w++)
         send_beat(OpInsert, 4'd15, 8'd255, w[4:0], (w % 2) ? '1 : '0);
      send_beat(OpLookup, 4'd15, 8'd255, 5'd0, '0);
      send_beat(OpLookup, 4'd0, 8'd0, 5'd0, '0);
   endtask

   task automatic test_dup_and_update_miss();
      send_beat(OpInsert, 4'd15, 8'd255, 5'd0, '1);
      send_beat(OpInsert, 4'd0, 8'd0, 5'd7, '1);
      send_beat(OpUpdate, 4'd0, 8'd0, 5'd0, '1);
      send_beat(OpUpdate, 4'd15, 8'd255, 5'd31, '1);
      send_beat(OpLookup, 4'd15, 8'd255, 5'd0, '0);
   endtask

   task automatic test_random(int items, int s_idle, int r_idle);
      int sent;
      int pick;
      int sel;
      sent = 0;
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      while (sent < items) begin
         pick = $urandom_range(99);
         sel = $urandom_range(5);
         if (pick < 35) begin
            send_block(OpInsert, pool_disk[sel], pool_blk[sel], 8, sent);
         end else if (pick < 50) begin
            send_block(OpUpdate, pool_disk[sel], pool_blk[sel], 8, sent);
         end else if (pick < 85) begin
            send_beat(OpLookup, pool_disk[sel], pool_blk[sel], 5'($urandom),
                      {$urandom, $urandom});
            sent++;
         end else begin
            send_beat(2'($urandom), 4'($urandom), 8'($urandom), 5'($urandom),
                      {$urandom, $urandom});
            sent++;
         end
      end
   endtask

   // response monitor and receiver stall
   always @(posedge clock) begin
      rsp_beat_t e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $error("unexpected response beat, status %0d", rsp_status);
               failures++;
            end else begin
               e = pending_rsp_q.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  failures++;
               end
               if (rsp_read_word !== e.word) begin
                  $error("read_word: expected %h, got %h", e.word, rsp_read_word);
                  failures++;
               end
               if (rsp_read_index !== e.index) begin
                  $error("read_index: expected %0d, got %0d", e.index, rsp_read_index);
                  failures++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_last);
                  failures++;
               end
               if (rsp_hit_total !== e.hits) begin
                  $error("hit_total: expected %0d, got %0d", e.hits, rsp_hit_total);
                  failures++;
               end
               if (rsp_query_total !== e.queries) begin
                  $error("query_total: expected %0d, got %0d", e.queries, rsp_query_total);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog on beats moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      active_n = 0;
      hit_cnt = '0;
      query_cnt = '0;
      cur_slot = 0;
      cur_status = StDone;
      for (int i = 0; i < NumEntries; i++) begin
         ent_valid[i] = 1'b0;
         ent_disk[i] = '0;
         ent_blk[i] = '0;
         ent_uses[i] = 0;
      end
      for (int i = 0; i < StoreDepth; i++) begin
         blk_data[i] = '0;
         blk_written[i] = 1'b0;
      end
      pool_disk[0] = 4'd15;
      pool_blk[0] = 8'd255;
      pool_disk[1] = 4'd0;
      pool_blk[1] = 8'd0;
      for (int i = 2; i < 6; i++) begin
         pool_disk[i] = 4'($urandom);
         pool_blk[i] = 8'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled();
      test_fill_and_lookup();
      test_dup_and_update_miss();
      write_entries(7'd2);
      test_random(120, 23, 51);
      write_entries(7'd3);
      test_random(120, 51, 23);
      write_entries(7'd64);
      test_random(120, 0, 0);
      write_entries(7'($urandom_range(4, 6)));
      test_random(110, 0, 0);

      drain();
      if (failures == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
